### rtl/core/pcr_pkg.sv
// Package for the particle collision resolver: widths, codes, state and
// operation types and the saturation helper. No dependencies.
`timescale 1ns / 1ps

package pcr_pkg;

   localparam int MAX_PARTICLES_DEF = 64;

   localparam int POS_W   = 24;
   localparam int RAD_W   = 16;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int COEF_W  = 16;
   localparam int CTC_W   = 6;
   localparam int SLOT_W  = 2 * POS_W + RAD_W;
   localparam int RSUM_W  = RAD_W + 1;
   localparam int DIFF_W  = POS_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int MAG_W   = SQ_W + 1;
   localparam int ROOT_W  = 2 * RSUM_W;
   localparam int NUM_W   = 2 * RSUM_W;
   localparam int CMP_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 80;

   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [CTC_W-1:0] CTC_MAX = {CTC_W{1'b1}};
   localparam logic [COEF_W-1:0] COEF_RESET = 16'h8000;

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_RESOLVE = 2'd1,
      MODE_READ    = 2'd2,
      MODE_NONE    = 2'd3
   } pcr_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF = 2'd0,
      CSR_COUNT = 2'd1
   } pcr_csr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SUBJ, S_FETCH, S_PART, S_SQR, S_MAG,
      S_ROOT, S_DEL, S_DIVGO, S_DIVWAIT, S_APPLY, S_STORE, S_FINISH
   } pcr_state_type;

   typedef enum logic [2:0] {
      OP_SHS, OP_SHP, OP_QSX, OP_QSY, OP_QPX, OP_QPY
   } pcr_op_type;

   // Clamp a widened signed sum to the signed position range.
   function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
      logic signed [POS_W+1:0] hi;
      logic signed [POS_W+1:0] lo;
      hi = {{2{1'b0}}, POS_MAX};
      lo = {{2{1'b1}}, POS_MIN};
      if (v > hi) begin
         sat_pos = POS_MAX;
      end else if (v < lo) begin
         sat_pos = POS_MIN;
      end else begin
         sat_pos = v[POS_W-1:0];
      end
   endfunction

endpackage

### rtl/core/pcr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps

module pcr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/pcr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pcr_pkg for default widths.
`timescale 1ns / 1ps

module pcr_div #(
   parameter int NW = pcr_pkg::NUM_W,
   parameter int DW = pcr_pkg::RSUM_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NW-2:0], fits};
         rem_ff <= fits ? DW'(shifted - {1'b0, den_ff}) : shifted[DW-1:0];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

`ifndef SYNTH
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff)) else $error("divider remainder out of range");
`endif
endmodule

### rtl/core/particle_collision_resolver.sv
// Top level of the particle collision resolver: command sequencer, pair
// arithmetic and result register. Depends on pcr_pkg, pcr_ram and pcr_div.
`timescale 1ns / 1ps

//  channel | ports                            | direction | moves
//  --------+----------------------------------+-----------+------------------------------
//  req     | req_tvalid req_tready req_tdata  | in        | one command item
//          | req_tuser                        |           |
//  rsp     | rsp_tvalid rsp_tready rsp_tdata  | out       | one result item (read/resolve)
//  csr     | csr_valid csr_ready csr_index    | in        | one register write
//          | csr_data                         |           |
//
// One item is worked on at a time. A resolve of an active subject reads its own
// slot and then walks the partners, skipping its own index and any partner that
// does not overlap. Each contact costs a square root (17 steps and the load of
// the result), the depth, six divisions in the shared divider and the partner
// write-back. The particle store is a single RAM with one read and one write
// port; its contents are undefined until written and reset does not touch it.
// Reset returns the sequencer to idle, clears the result valid flag and the
// count register and sets the coefficient register to 8000h. A stalled result
// holds the sequencer in its final state only.

module particle_collision_resolver #(
   parameter int MAX_PARTICLES = pcr_pkg::MAX_PARTICLES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // index [5:0], pos_x [29:6], pos_y [53:30], radius [69:54], zero [71:70]
   input  logic [pcr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode [1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_index [5:0], out_x [29:6], out_y [53:30], out_radius [69:54],
   // contacts [75:70], zero [79:76]
   output logic [pcr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcr_pkg::COEF_W-1:0]         csr_data
);
   import pcr_pkg::*;

   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CW = $clog2(MAX_PARTICLES + 1);

   // Sequencer and configuration.
   pcr_state_type state_ff, state_in;
   pcr_mode_type  mode_ff;
   pcr_op_type    op_ff;
   logic [COEF_W-1:0] coeff_ff;
   logic [CNT_W-1:0]  count_ff;

   // Command payload.
   logic [IDX_W-1:0] idx_ff;
   logic [POS_W-1:0] inx_ff, iny_ff;
   logic [RAD_W-1:0] inr_ff;

   // Subject and partner.
   logic [POS_W-1:0] sx_ff, sy_ff, px_ff, py_ff;
   logic [RAD_W-1:0] sr_ff, pr_ff;
   logic [CW-1:0]    j_ff;
   logic [CTC_W-1:0] contacts_ff;

   // Pair arithmetic.
   logic [DIFF_W-1:0] adx_ff, ady_ff;
   logic              dxn_ff, dyn_ff;
   logic [RSUM_W-1:0] rsum_ff, dist_ff, del_ff, shs_ff, shp_ff;
   logic [RSUM_W-1:0] qsx_ff, qsy_ff, qpx_ff, qpy_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [ROOT_W-1:0] rsq_ff, rt_v_ff;
   logic [ROOT_W:0]   rt_res_ff, rt_bit_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Store and divider.
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [SLOT_W-1:0] ram_wdata, ram_rdata;
   logic              div_start, div_busy, div_done;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [RSUM_W-1:0] div_den, mul_a, mul_b;

   // Decoded conditions.
   logic              req_accept, rsp_load;
   logic [CMP_W-1:0]  n_active, idx_ext, j_ext;
   logic              idx_in_store, idx_active, walk_done, walk_self;
   logic [MAG_W-1:0]  mag;
   logic              pair_skip;
   logic [ROOT_W:0]   rt_try;
   logic [POS_W-1:0]  nsx, nsy, npx, npy;
   logic [DIFF_W:0]   dx_w, dy_w;
   logic [RSUM_W+COEF_W-1:0] del_prod;
   logic [RSUM_W-1:0] pen;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign n_active = ({{(CMP_W-CNT_W){1'b0}}, count_ff} > CMP_W'(MAX_PARTICLES))
                     ? CMP_W'(MAX_PARTICLES) : {{(CMP_W-CNT_W){1'b0}}, count_ff};
   assign idx_ext      = {{(CMP_W-IDX_W){1'b0}}, idx_ff};
   assign j_ext        = CMP_W'(j_ff);
   assign idx_in_store = idx_ext < CMP_W'(MAX_PARTICLES);
   assign idx_active   = idx_ext < n_active;
   assign walk_done    = j_ext == n_active;
   assign walk_self    = j_ext == idx_ext;

   assign mag       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign pair_skip = (mag == '0) || (mag >= MAG_W'(rsq_ff));
   assign rt_try    = rt_res_ff + rt_bit_ff;
   assign pen       = rsum_ff - dist_ff;
   assign del_prod  = coeff_ff * pen;

   // New positions; the partner moves against d, the subject along it.
   assign nsx = sat_pos(dxn_ff ? (POS_W+2)'($signed(sx_ff)) - (POS_W+2)'(qsx_ff)
                               : (POS_W+2)'($signed(sx_ff)) + (POS_W+2)'(qsx_ff));
   assign nsy = sat_pos(dyn_ff ? (POS_W+2)'($signed(sy_ff)) - (POS_W+2)'(qsy_ff)
                               : (POS_W+2)'($signed(sy_ff)) + (POS_W+2)'(qsy_ff));
   assign npx = sat_pos(dxn_ff ? (POS_W+2)'($signed(px_ff)) + (POS_W+2)'(qpx_ff)
                               : (POS_W+2)'($signed(px_ff)) - (POS_W+2)'(qpx_ff));
   assign npy = sat_pos(dyn_ff ? (POS_W+2)'($signed(py_ff)) + (POS_W+2)'(qpy_ff)
                               : (POS_W+2)'($signed(py_ff)) - (POS_W+2)'(qpy_ff));

   assign dx_w = {{2{sx_ff[POS_W-1]}}, sx_ff} - {{2{ram_rdata[POS_W-1]}},
                 ram_rdata[POS_W-1:0]};
   assign dy_w = {{2{sy_ff[POS_W-1]}}, sy_ff} - {{2{ram_rdata[2*POS_W-1]}},
                 ram_rdata[2*POS_W-1:POS_W]};

   // Operand selection for the shared multiplier in front of the divider.
   always_comb begin
      unique case (op_ff)
         OP_SHS:  begin mul_a = del_ff;             mul_b = {1'b0, pr_ff}; end
         OP_SHP:  begin mul_a = del_ff;             mul_b = {1'b0, sr_ff}; end
         OP_QSX:  begin mul_a = adx_ff[RSUM_W-1:0]; mul_b = shs_ff;        end
         OP_QSY:  begin mul_a = ady_ff[RSUM_W-1:0]; mul_b = shs_ff;        end
         OP_QPX:  begin mul_a = adx_ff[RSUM_W-1:0]; mul_b = shp_ff;        end
         OP_QPY:  begin mul_a = ady_ff[RSUM_W-1:0]; mul_b = shp_ff;        end
         default: begin mul_a = '0;                 mul_b = '0;            end
      endcase
   end
   assign div_num = mul_a * mul_b;
   assign div_den = ((op_ff == OP_SHS) || (op_ff == OP_SHP)) ? rsum_ff : dist_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_accept) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (mode_ff)
               MODE_WRITE, MODE_NONE: state_in = S_IDLE;
               MODE_RESOLVE, MODE_READ: state_in = idx_in_store ? S_SUBJ : S_FINISH;
               default: state_in = S_IDLE;
            endcase
         end
         S_SUBJ: begin
            state_in = ((mode_ff == MODE_RESOLVE) && idx_active) ? S_FETCH : S_FINISH;
         end
         S_FETCH: begin
            priority if (walk_done) state_in = S_STORE;
            else if (walk_self)     state_in = S_FETCH;
            else                    state_in = S_PART;
         end
         S_PART:    state_in = S_SQR;
         S_SQR:     state_in = S_MAG;
         S_MAG:     state_in = pair_skip ? S_FETCH : S_ROOT;
         S_ROOT:    if (rt_bit_ff == '0) state_in = S_DEL;
         S_DEL:     state_in = S_DIVGO;
         S_DIVGO:   state_in = S_DIVWAIT;
         S_DIVWAIT: begin
            if (div_done) state_in = (op_ff == OP_QPY) ? S_APPLY : S_DIVGO;
         end
         S_APPLY:   state_in = S_FETCH;
         S_STORE:   state_in = S_FINISH;
         S_FINISH:  if (rsp_load) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = AW'(idx_ff);
      ram_wdata  = {inr_ff, iny_ff, inx_ff};
      ram_raddr  = AW'(idx_ff);
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE:     req_tready = 1'b1;
         S_DISPATCH: ram_we = (mode_ff == MODE_WRITE) && idx_in_store;
         S_FETCH:    ram_raddr = j_ff[AW-1:0];
         S_DIVGO:    div_start = 1'b1;
         S_APPLY: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[AW-1:0];
            ram_wdata = {pr_ff, npy, npx};
         end
         S_STORE: begin
            ram_we    = 1'b1;
            ram_wdata = {sr_ff, sy_ff, sx_ff};
         end
         S_FINISH:   rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         coeff_ff     <= COEF_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COEFF) coeff_ff <= csr_data;
            if (csr_index == CSR_COUNT) count_ff <= csr_data[CNT_W-1:0];
         end
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {{(RSP_DATA_W-IDX_W-2*POS_W-RAD_W-CTC_W){1'b0}},
                         contacts_ff, sr_ff, sy_ff, sx_ff, idx_ff};
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_ff     <= pcr_mode_type'(req_tuser);
               idx_ff      <= req_tdata[IDX_W-1:0];
               inx_ff      <= req_tdata[IDX_W +: POS_W];
               iny_ff      <= req_tdata[IDX_W+POS_W +: POS_W];
               inr_ff      <= req_tdata[IDX_W+2*POS_W +: RAD_W];
               sx_ff       <= '0;
               sy_ff       <= '0;
               sr_ff       <= '0;
               contacts_ff <= '0;
            end
         end
         S_SUBJ: begin
            sx_ff <= ram_rdata[POS_W-1:0];
            sy_ff <= ram_rdata[2*POS_W-1:POS_W];
            sr_ff <= ram_rdata[SLOT_W-1:2*POS_W];
            j_ff  <= '0;
         end
         S_FETCH: if (walk_self && !walk_done) j_ff <= j_ff + 1'b1;
         S_PART: begin
            px_ff   <= ram_rdata[POS_W-1:0];
            py_ff   <= ram_rdata[2*POS_W-1:POS_W];
            pr_ff   <= ram_rdata[SLOT_W-1:2*POS_W];
            rsum_ff <= {1'b0, sr_ff} + {1'b0, ram_rdata[SLOT_W-1:2*POS_W]};
            dxn_ff  <= dx_w[DIFF_W];
            dyn_ff  <= dy_w[DIFF_W];
            adx_ff  <= dx_w[DIFF_W] ? DIFF_W'(-dx_w) : dx_w[DIFF_W-1:0];
            ady_ff  <= dy_w[DIFF_W] ? DIFF_W'(-dy_w) : dy_w[DIFF_W-1:0];
         end
         S_SQR: begin
            sqx_ff <= adx_ff * adx_ff;
            sqy_ff <= ady_ff * ady_ff;
            rsq_ff <= rsum_ff * rsum_ff;
         end
         S_MAG: begin
            if (pair_skip) begin
               j_ff <= j_ff + 1'b1;
            end
            // A resolved pair has mag below rsum squared, so it fits the root width.
            rt_v_ff   <= mag[ROOT_W-1:0];
            rt_res_ff <= '0;
            rt_bit_ff <= (ROOT_W+1)'(1) << (ROOT_W - 2);
            op_ff     <= OP_SHS;
         end
         S_ROOT: begin
            if (rt_bit_ff != '0) begin
               if ({1'b0, rt_v_ff} >= rt_try) begin
                  rt_v_ff   <= ROOT_W'({1'b0, rt_v_ff} - rt_try);
                  rt_res_ff <= (rt_res_ff >> 1) + rt_bit_ff;
               end else begin
                  rt_res_ff <= rt_res_ff >> 1;
               end
               rt_bit_ff <= rt_bit_ff >> 2;
            end else begin
               dist_ff <= rt_res_ff[RSUM_W-1:0];
            end
         end
         S_DEL: del_ff <= del_prod[COEF_W +: RSUM_W];
         S_DIVWAIT: begin
            if (div_done) begin
               unique case (op_ff)
                  OP_SHS: shs_ff <= div_quo[RSUM_W-1:0];
                  OP_SHP: shp_ff <= div_quo[RSUM_W-1:0];
                  OP_QSX: qsx_ff <= div_quo[RSUM_W-1:0];
                  OP_QSY: qsy_ff <= div_quo[RSUM_W-1:0];
                  OP_QPX: qpx_ff <= div_quo[RSUM_W-1:0];
                  OP_QPY: qpy_ff <= div_quo[RSUM_W-1:0];
                  default: ;
               endcase
               if (op_ff != OP_QPY) op_ff <= pcr_op_type'(op_ff + 1'b1);
            end
         end
         S_APPLY: begin
            sx_ff <= nsx;
            sy_ff <= nsy;
            j_ff  <= j_ff + 1'b1;
            if (contacts_ff != CTC_MAX) contacts_ff <= contacts_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pcr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_PARTICLES),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pcr_div #(
      .NW (NUM_W),
      .DW (RSUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

`ifndef SYNTH
   a_partner_not_subject: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (j_ext != idx_ext))
      else $error("partner write hit the subject slot");
   a_dist_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL) |-> (dist_ff != '0))
      else $error("resolved pair with zero distance");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("division started while the divider is busy");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("second item taken while one is in work");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");
`endif
endmodule
